/* rtl/core/bthk_pkg.sv */
package bthk_pkg;

  localparam int MAX_KEEP   = 16;
  localparam int ID_W       = 24;
  localparam int DIST_W     = 32;
  localparam int KEEP_W     = 5;
  localparam int KEEP_RESET = 16;
  localparam int IDX_W      = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int CNT_W      = $clog2(MAX_KEEP + 1);
  localparam int CH_W       = IDX_W + 2;
  localparam int ENTRY_W    = ID_W + DIST_W;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DRAIN  = 1'b1;

  // Distance in the upper bits: one unsigned compare gives distance-then-id order.
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [ID_W-1:0]   id;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_FULL_CMP,
    ST_DN_RDL,
    ST_DN_RDR,
    ST_DN_PICK,
    ST_DN_CMP,
    ST_DR_ROOT,
    ST_DR_LAST,
    ST_DR_SET,
    ST_DR_PUT,
    ST_EM_RD,
    ST_EM_LD,
    ST_EM_WAIT
  } st_t;

endpackage

/* rtl/core/bthk_if.sv */
interface bthk_in_if;
  import bthk_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [ID_W-1:0]   cand_id;
  logic [DIST_W-1:0] cand_distance;

  modport source (output valid, output command, output cand_id, output cand_distance,
                  input ready);
  modport sink   (input valid, input command, input cand_id, input cand_distance,
                  output ready);
endinterface

interface bthk_out_if;
  import bthk_pkg::*;

  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   out_id;
  logic [DIST_W-1:0] out_distance;
  logic              last_flag;

  modport source (output valid, output out_id, output out_distance, output last_flag,
                  input ready);
  modport sink   (input valid, input out_id, input out_distance, input last_flag,
                  output ready);
endinterface

/* rtl/core/bthk_ram.sv */
module bthk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/bthk_worse.sv */
module bthk_worse (
  input  bthk_pkg::entry_t a,
  input  bthk_pkg::entry_t b,
  output logic             a_worse
);
  import bthk_pkg::*;

  // Larger distance is worse; equal distance, larger id is worse.
  assign a_worse = (a > b);

endmodule

/* rtl/core/bthk_seq.sv */
module bthk_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  bthk_in_if.sink                       in_chan,
  bthk_out_if.source                    out_chan,
  input  logic [bthk_pkg::CNT_W-1:0]    eff_k,
  output bthk_pkg::ram_req_t            ram_req,
  input  bthk_pkg::entry_t              ram_rdata,
  output bthk_pkg::entry_t              cmp_a,
  output bthk_pkg::entry_t              cmp_b,
  input  logic                          cmp_worse
);
  import bthk_pkg::*;

  st_t              st_r, st_nxt;
  entry_t           cur_r, cur_nxt;
  entry_t           child_r, child_nxt;
  entry_t           pop_r, pop_nxt;
  entry_t           odata_r, odata_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [IDX_W-1:0] cidx_r, cidx_nxt;
  logic [IDX_W-1:0] emit_r, emit_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] dn_r, dn_nxt;
  logic             drain_r, drain_nxt;
  logic             ovalid_r, ovalid_nxt;
  logic             olast_r, olast_nxt;

  logic [CH_W-1:0]  lch;
  logic [CH_W-1:0]  rch;
  logic [CH_W-1:0]  fill_x;
  logic [IDX_W-1:0] parent;
  logic [CNT_W-1:0] fill_dec;

  assign lch      = {1'b0, pos_r, 1'b1};
  assign rch      = lch + CH_W'(1);
  assign fill_x   = CH_W'(fill_r);
  assign parent   = (pos_r - IDX_W'(1)) >> 1;
  assign fill_dec = fill_r - CNT_W'(1);

  assign in_chan.ready         = (st_r == ST_IDLE);
  assign out_chan.valid        = ovalid_r;
  assign out_chan.out_id       = odata_r.id;
  assign out_chan.out_distance = odata_r.distance;
  assign out_chan.last_flag    = olast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      fill_r   <= '0;
      drain_r  <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      fill_r   <= fill_nxt;
      drain_r  <= drain_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    child_r <= child_nxt;
    pop_r   <= pop_nxt;
    odata_r <= odata_nxt;
    pos_r   <= pos_nxt;
    cidx_r  <= cidx_nxt;
    emit_r  <= emit_nxt;
    dn_r    <= dn_nxt;
    olast_r <= olast_nxt;
  end

  always_comb begin
    st_nxt     = st_r;
    cur_nxt    = cur_r;
    child_nxt  = child_r;
    pop_nxt    = pop_r;
    odata_nxt  = odata_r;
    pos_nxt    = pos_r;
    cidx_nxt   = cidx_r;
    emit_nxt   = emit_r;
    fill_nxt   = fill_r;
    dn_nxt     = dn_r;
    drain_nxt  = drain_r;
    ovalid_nxt = ovalid_r;
    olast_nxt  = olast_r;

    ram_req.we    = 1'b0;
    ram_req.waddr = pos_r;
    ram_req.wdata = cur_r;
    ram_req.raddr = '0;

    cmp_a = cur_r;
    cmp_b = ram_rdata;

    case (st_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          cur_nxt.id       = in_chan.cand_id;
          cur_nxt.distance = in_chan.cand_distance;
          if (in_chan.command == CMD_INSERT) begin
            if (fill_r < eff_k && fill_r < CNT_W'(MAX_KEEP)) begin
              pos_nxt  = fill_r[IDX_W-1:0];
              fill_nxt = fill_r + CNT_W'(1);
              st_nxt   = ST_UP_RD;
            end else if (fill_r != '0) begin
              ram_req.raddr = '0;
              st_nxt        = ST_FULL_CMP;
            end
          end else if (fill_r != '0) begin
            dn_nxt    = fill_r;
            drain_nxt = 1'b1;
            st_nxt    = ST_DR_ROOT;
          end
        end
      end

      // Sift up: hole moves toward the root, new item written once at the end.
      ST_UP_RD: begin
        if (pos_r == '0) begin
          ram_req.we = 1'b1;
          st_nxt     = ST_IDLE;
        end else begin
          ram_req.raddr = parent;
          st_nxt        = ST_UP_CMP;
        end
      end

      ST_UP_CMP: begin
        cmp_a = cur_r;
        cmp_b = ram_rdata;
        ram_req.we = 1'b1;
        if (cmp_worse) begin
          ram_req.wdata = ram_rdata;
          pos_nxt       = parent;
          st_nxt        = ST_UP_RD;
        end else begin
          st_nxt = ST_IDLE;
        end
      end

      // Full heap: replace the root only when strictly better.
      ST_FULL_CMP: begin
        cmp_a = ram_rdata;
        cmp_b = cur_r;
        if (cmp_worse) begin
          pos_nxt = '0;
          st_nxt  = ST_DN_RDL;
        end else begin
          st_nxt = ST_IDLE;
        end
      end

      // Sift down over fill_r entries, hole at pos_r.
      ST_DN_RDL: begin
        if (lch >= fill_x) begin
          ram_req.we = 1'b1;
          st_nxt     = drain_r ? ST_DR_PUT : ST_IDLE;
        end else begin
          ram_req.raddr = lch[IDX_W-1:0];
          st_nxt        = ST_DN_RDR;
        end
      end

      ST_DN_RDR: begin
        child_nxt = ram_rdata;
        cidx_nxt  = lch[IDX_W-1:0];
        if (rch < fill_x) begin
          ram_req.raddr = rch[IDX_W-1:0];
          st_nxt        = ST_DN_PICK;
        end else begin
          st_nxt = ST_DN_CMP;
        end
      end

      ST_DN_PICK: begin
        cmp_a = ram_rdata;
        cmp_b = child_r;
        if (cmp_worse) begin
          child_nxt = ram_rdata;
          cidx_nxt  = rch[IDX_W-1:0];
        end
        st_nxt = ST_DN_CMP;
      end

      ST_DN_CMP: begin
        cmp_a = child_r;
        cmp_b = cur_r;
        ram_req.we = 1'b1;
        if (cmp_worse) begin
          ram_req.wdata = child_r;
          pos_nxt       = cidx_r;
          st_nxt        = ST_DN_RDL;
        end else begin
          st_nxt = drain_r ? ST_DR_PUT : ST_IDLE;
        end
      end

      // Drain: heapsort in place, popped root goes to the freed tail slot.
      ST_DR_ROOT: begin
        ram_req.raddr = '0;
        st_nxt        = ST_DR_LAST;
      end

      ST_DR_LAST: begin
        pop_nxt       = ram_rdata;
        ram_req.raddr = fill_dec[IDX_W-1:0];
        fill_nxt      = fill_dec;
        st_nxt        = ST_DR_SET;
      end

      ST_DR_SET: begin
        cur_nxt = ram_rdata;
        pos_nxt = '0;
        st_nxt  = ST_DN_RDL;
      end

      ST_DR_PUT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = fill_r[IDX_W-1:0];
        ram_req.wdata = pop_r;
        if (fill_r == '0) begin
          emit_nxt = '0;
          st_nxt   = ST_EM_RD;
        end else begin
          st_nxt = ST_DR_ROOT;
        end
      end

      ST_EM_RD: begin
        ram_req.raddr = emit_r;
        st_nxt        = ST_EM_LD;
      end

      ST_EM_LD: begin
        odata_nxt  = ram_rdata;
        olast_nxt  = ((CNT_W'(emit_r) + CNT_W'(1)) == dn_r);
        ovalid_nxt = 1'b1;
        st_nxt     = ST_EM_WAIT;
      end

      ST_EM_WAIT: begin
        if (out_chan.ready) begin
          ovalid_nxt = 1'b0;
          if (olast_r) begin
            drain_nxt = 1'b0;
            st_nxt    = ST_IDLE;
          end else begin
            emit_nxt = emit_r + IDX_W'(1);
            st_nxt   = ST_EM_RD;
          end
        end
      end

      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/bounded_top_k_nearest_heap.sv */
// Bounded top-K nearest selector.
// Keeps the K best candidates (smallest distance, lower id wins ties) in a
// max-heap held in a single-port-read RAM; the root is the worst kept entry.
// Input channel in_chan: command 0 inserts (cand_id, cand_distance), command 1
// drains. Output channel out_chan: one transaction per kept entry on a drain,
// ascending distance, last_flag on the final one. Inserts return nothing; a
// drain of an empty heap returns nothing and leaves the block idle at once.
// cfg_we/cfg_wdata set K (keep_count); 0 acts as 1, values above the heap
// depth saturate. Write it only while the block is idle.
// Flow: the block works on one transaction at a time and drops in_chan.ready
// until done. One compare unit and one RAM read port set the pace:
//   insert while filling : sifts up, one parent read and compare per level
//                          climbed, stopping below the root or at it
//   insert when full     : root compare; rejects, else replaces the root
//                          and sifts down, up to two child reads per level
//   drain of n entries   : each pop sifts down, then results are read out.
// A stalled receiver just holds the output register; nothing is lost.
// Reset (synchronous, rst_n low) empties the heap and sets K to 16.
module bounded_top_k_nearest_heap (
  input  logic                          clk,
  input  logic                          rst_n,
  bthk_in_if.sink                       in_chan,
  bthk_out_if.source                    out_chan,
  input  logic                          cfg_we,
  input  logic [bthk_pkg::KEEP_W-1:0]   cfg_wdata
);
  import bthk_pkg::*;

  logic [KEEP_W-1:0] keep_r;
  logic [CNT_W-1:0]  eff_k;
  ram_req_t          ram_req;
  logic [ENTRY_W-1:0] ram_rdata_raw;
  entry_t            ram_rdata;
  entry_t            cmp_a;
  entry_t            cmp_b;
  logic              cmp_worse;

  // K register, no read-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_r <= KEEP_W'(KEEP_RESET);
    end else if (cfg_we) begin
      keep_r <= cfg_wdata;
    end
  end

  // Clamp K into 1..MAX_KEEP.
  always_comb begin
    if (keep_r == '0) begin
      eff_k = CNT_W'(1);
    end else if (int'(keep_r) > MAX_KEEP) begin
      eff_k = CNT_W'(MAX_KEEP);
    end else begin
      eff_k = CNT_W'(keep_r);
    end
  end

  assign ram_rdata = entry_t'(ram_rdata_raw);

  bthk_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_KEEP)
  ) u_heap_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata_raw)
  );

  // Single shared ordering compare used by every sift step.
  bthk_worse u_worse (
    .a       (cmp_a),
    .b       (cmp_b),
    .a_worse (cmp_worse)
  );

  bthk_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .eff_k     (eff_k),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .cmp_a     (cmp_a),
    .cmp_b     (cmp_b),
    .cmp_worse (cmp_worse)
  );

endmodule
